// ----- rtl/mbc1_pkg.sv -----
package mbc1_pkg;

  localparam int unsigned DefaultMaxRomBanks = 128;

  localparam int unsigned BankW     = 7;
  localparam int unsigned PhysW     = 21;
  localparam int unsigned RamOffW   = 15;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 24;

  localparam logic [3:0] RamEnableKey = 4'hA;

  typedef enum logic [1:0] {
    KIND_ROM_ONLY = 2'd0,
    KIND_MBC1     = 2'd1,
    KIND_OTHER    = 2'd2,
    KIND_UNDEF    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_MAPPER_KIND    = 2'd0,
    CFG_ROM_BANK_COUNT = 2'd1,
    CFG_CART_RAM_BYTES = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REGION_ROM     = 2'd0,
    REGION_RAM     = 2'd1,
    REGION_IGNORED = 2'd2,
    REGION_NONE    = 2'd3
  } region_e;

  typedef enum logic [1:0] {
    CTL_RAM_ENABLE = 2'd0,
    CTL_ROM_BANK   = 2'd1,
    CTL_UPPER_BANK = 2'd2,
    CTL_MODE       = 2'd3
  } ctl_sel_e;

  typedef struct packed {
    kind_e       mapper_kind;
    logic [7:0]  rom_bank_count;
    logic [15:0] cart_ram_bytes;
  } cfg_t;

  typedef struct packed {
    logic       ram_enable;
    logic [4:0] rom_bank_low;
    logic [1:0] upper_bank_bits;
    logic       banking_mode;
  } bank_t;

  typedef struct packed {
    logic       valid;
    ctl_sel_e   sel;
    logic [7:0] data;
  } ctl_wr_t;

  typedef struct packed {
    logic        command;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    region_e          region;
    logic [PhysW-1:0] physical_address;
    logic             register_updated;
  } result_t;

endpackage

// ----- rtl/mbc1_bank_regs.sv -----
module mbc1_bank_regs import mbc1_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  ctl_wr_t              ctl_wr_i,
  output cfg_t                 cfg_o,
  output bank_t                bank_o
);

  cfg_t  cfg_q;
  bank_t bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mapper_kind    <= KIND_ROM_ONLY;
      cfg_q.rom_bank_count <= 8'd2;
      cfg_q.cart_ram_bytes <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAPPER_KIND:    cfg_q.mapper_kind    <= kind_e'(cfg_data_i[1:0]);
        CFG_ROM_BANK_COUNT: cfg_q.rom_bank_count <= cfg_data_i[7:0];
        CFG_CART_RAM_BYTES: cfg_q.cart_ram_bytes <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q.ram_enable      <= 1'b0;
      bank_q.rom_bank_low    <= 5'd1;
      bank_q.upper_bank_bits <= 2'd0;
      bank_q.banking_mode    <= 1'b0;
    end else if (ctl_wr_i.valid) begin
      case (ctl_wr_i.sel)
        CTL_RAM_ENABLE: bank_q.ram_enable <= (ctl_wr_i.data[3:0] == RamEnableKey);
        CTL_ROM_BANK: begin
          // bank 0 in the low register selects bank 1
          bank_q.rom_bank_low <= (ctl_wr_i.data[4:0] == 5'd0) ? 5'd1 : ctl_wr_i.data[4:0];
        end
        CTL_UPPER_BANK: bank_q.upper_bank_bits <= ctl_wr_i.data[1:0];
        CTL_MODE:       bank_q.banking_mode    <= ctl_wr_i.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_o  = cfg_q;
  assign bank_o = bank_q;

endmodule

// ----- rtl/mbc1_translate.sv -----
module mbc1_translate import mbc1_pkg::*; #(
  parameter int unsigned MaxRomBanks = DefaultMaxRomBanks
) (
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  input  bank_t   bank_i,
  output result_t result_o,
  output ctl_wr_t ctl_wr_o
);

  localparam logic [BankW-1:0] BankMask = BankW'(MaxRomBanks - 1);

  logic [7:0]         count_m1;
  logic [BankW-1:0]   bank_mask;
  logic               mbc1_mode1;
  logic [BankW-1:0]   lo_bank;
  logic [4:0]         low_fixed;
  logic [BankW-1:0]   hi_bank;
  logic [BankW-1:0]   win_bank;
  logic [1:0]         ram_bank;
  logic [RamOffW-1:0] ram_off;
  logic               ram_hit;
  logic               is_mbc1;

  always_comb begin
    count_m1   = cfg_i.rom_bank_count - 8'd1;
    bank_mask  = (cfg_i.rom_bank_count != 8'd0) ? (count_m1[BankW-1:0] & BankMask) : BankMask;
    is_mbc1    = (cfg_i.mapper_kind == KIND_MBC1);
    mbc1_mode1 = is_mbc1 && bank_i.banking_mode;

    lo_bank   = mbc1_mode1 ? ({bank_i.upper_bank_bits, 5'd0} & bank_mask) : '0;
    low_fixed = (bank_i.rom_bank_low == 5'd0) ? 5'd1 : bank_i.rom_bank_low;
    hi_bank   = (cfg_i.mapper_kind == KIND_ROM_ONLY) ? BankW'(1)
              : ({bank_i.upper_bank_bits, low_fixed} & bank_mask);
    win_bank  = item_i.bus_address[14] ? hi_bank : lo_bank;

    ram_bank = mbc1_mode1 ? bank_i.upper_bank_bits : 2'd0;
    ram_off  = {ram_bank, item_i.bus_address[12:0]};
    ram_hit  = (cfg_i.cart_ram_bytes != 16'd0) && bank_i.ram_enable
            && ({1'b0, ram_off} < cfg_i.cart_ram_bytes);

    result_o.region           = REGION_NONE;
    result_o.physical_address = '0;
    result_o.register_updated = 1'b0;
    ctl_wr_o.valid = 1'b0;
    ctl_wr_o.sel   = ctl_sel_e'(item_i.bus_address[14:13]);
    ctl_wr_o.data  = item_i.write_data;

    if (!item_i.bus_address[15]) begin
      if (item_i.command) begin
        result_o.region           = REGION_IGNORED;
        result_o.register_updated = is_mbc1;
        ctl_wr_o.valid            = is_mbc1;
      end else begin
        result_o.region           = REGION_ROM;
        result_o.physical_address = {win_bank, item_i.bus_address[13:0]};
      end
    end else if (item_i.bus_address[15:13] == 3'b101) begin
      result_o.region = REGION_IGNORED;
      if (ram_hit) begin
        result_o.region           = REGION_RAM;
        result_o.physical_address = PhysW'(ram_off);
      end
    end
  end

endmodule

// ----- rtl/mbc1_bank_mapper.sv -----
// Cartridge bank controller: maps one CPU bus access to a ROM or cart RAM
// byte address.
// Input channel s_axis: one access per item (read/write, address, data byte).
// Output channel m_axis: one result per access (region, physical address,
// control register write strobe), in the order the accesses came in.
// Configuration: cfg_we_i writes register cfg_index_i (0 mapper kind,
// 1 ROM bank count, 2 cart RAM size); write only while no item is in flight.
// Each result passes the input register, then the result register, before
// it is valid.
// Throughput: one item per cycle while m_axis_tready is high; the translation
// is a single level of address and bank logic between the input and result registers.
// Bank control writes take effect for the very next access.
// Reset: both pipeline stages empty, configuration at ROM only / 2 banks /
// no RAM, bank registers at RAM disabled, bank 1, upper bits 0, mode 0.
// Stall: while m_axis_tready is low the result holds and the input stage
// takes one more item only if it is empty; then s_axis_tready drops.
module mbc1_bank_mapper import mbc1_pkg::*; #(
  parameter int unsigned MaxRomBanks = DefaultMaxRomBanks
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,   // command, bus_address, write_data
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,   // region, physical_address, register_updated
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;

  logic    advance;
  logic    fire;
  cfg_t    cfg;
  bank_t   bank;
  result_t result;
  ctl_wr_t ctl_wr;
  ctl_wr_t ctl_wr_go;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    ctl_wr_go       = ctl_wr;
    ctl_wr_go.valid = ctl_wr.valid && fire;
  end

  mbc1_bank_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_wr_i    (ctl_wr_go),
    .cfg_o       (cfg),
    .bank_o      (bank)
  );

  mbc1_translate #(
    .MaxRomBanks (MaxRomBanks)
  ) u_translate (
    .item_i   (in_q),
    .cfg_i    (cfg),
    .bank_i   (bank),
    .result_o (result),
    .ctl_wr_o (ctl_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.command     <= s_axis_tdata[0];
      in_q.bus_address <= s_axis_tdata[16:1];
      in_q.write_data  <= s_axis_tdata[24:17];
    end
    if (fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.register_updated, out_q.physical_address, out_q.region};

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input not ready while result register is empty");

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed item did not reach result register");

  a_noaddr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.region == REGION_IGNORED || out_q.region == REGION_NONE)
      |-> out_q.physical_address == '0)
    else $error("non-zero address for open bus or non-cartridge region");

  a_update_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.register_updated |-> out_q.region == REGION_IGNORED)
    else $error("register write strobe on an access that maps memory");
`endif

endmodule
